>>> rtl/ccc_pkg.sv
// Shared types, field widths, reset values and calendar helpers for the
// calendar clock counter. No dependencies.
`default_nettype none

package ccc_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int INTERVAL_W = 17;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int YEAR_W     = 16;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;

  // Stream data widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;

  // Seconds-of-day arithmetic
  localparam int SOD_W  = 17;
  localparam int NEED_W = 18;

  // Reset values of the calendar
  localparam logic [YEAR_W-1:0]  RST_YEAR   = 16'd2017;
  localparam logic [MONTH_W-1:0] RST_MONTH  = 4'd11;
  localparam logic [DAY_W-1:0]   RST_DAY    = 5'd13;
  localparam logic [HOUR_W-1:0]  RST_HOUR   = 5'd9;
  localparam logic [MIN_W-1:0]   RST_MINUTE = 6'd45;

  // Divisibility by 25 on 16 bits: multiply by the inverse of 25 mod 2^16
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_LOAD  = 2'd2
  } ccc_cmd_t;

  typedef struct packed {
    ccc_cmd_t                command;
    logic [INTERVAL_W-1:0]   interval_seconds;
    logic [HOUR_W-1:0]       prev_hours;
    logic [MIN_W-1:0]        prev_minutes;
    logic [SEC_W-1:0]        prev_seconds;
    logic [YEAR_W-1:0]       load_year;
    logic [MONTH_W-1:0]      load_month;
    logic [DAY_W-1:0]        load_day;
    logic [HOUR_W-1:0]       load_hour;
    logic [MIN_W-1:0]        load_minute;
  } ccc_item_t;

  typedef struct packed {
    logic [SEC_W-1:0]   tod_seconds;
    logic [MIN_W-1:0]   tod_minutes;
    logic [HOUR_W-1:0]  tod_hours;
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]   cal_day;
    logic [HOUR_W-1:0]  cal_hour;
    logic [MIN_W-1:0]   cal_minute;
    logic               elapsed;
  } ccc_result_t;

  // Gregorian leap year: 4/100/400 rule
  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = year * INV25;
    div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
    return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
  endfunction

  // Days in a month; codes outside 1..12 have no length
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/calendar_clock_counter.sv
// A request accepted into the input register passes through the combinational core into
// the result register, and is offered on m_axis from there.
// Throughput: one request per cycle unless m_axis stalls; the carry chain is combinational.
// While a result waits, the input register takes one more request, then s_axis_tready drops.
// Reset (rst, synchronous): time of day 00:00:00, calendar 2017-11-13 09:45,
// both stream sides empty.
// Top level: stream ports, input register, result register. Depends on ccc_pkg, ccc_core.
`default_nettype none

module calendar_clock_counter
  import ccc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // tdata, low bit up: interval_seconds[16:0], prev_hours[21:17], prev_minutes[27:22],
  // prev_seconds[33:28], load_year[49:34], load_month[53:50], load_day[58:54],
  // load_hour[63:59], load_minute[69:64], zero pad[71:70]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [CMD_W-1:0]       s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata, low bit up: tod_seconds[5:0], tod_minutes[11:6], tod_hours[16:12],
  // cal_year[32:17], cal_month[36:33], cal_day[41:37], cal_hour[46:42],
  // cal_minute[52:47], elapsed[53], zero pad[55:54]
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic        in_valid;
  ccc_item_t   in_item;
  logic        out_valid;
  ccc_result_t out_result;
  ccc_result_t core_result;
  logic        advance;
  logic        core_en;

  // Move forward when the result register is free or being drained
  assign advance       = !out_valid || m_axis_tready;
  assign core_en       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.command          <= ccc_cmd_t'(s_axis_tuser);
      in_item.interval_seconds <= s_axis_tdata[16:0];
      in_item.prev_hours       <= s_axis_tdata[21:17];
      in_item.prev_minutes     <= s_axis_tdata[27:22];
      in_item.prev_seconds     <= s_axis_tdata[33:28];
      in_item.load_year        <= s_axis_tdata[49:34];
      in_item.load_month       <= s_axis_tdata[53:50];
      in_item.load_day         <= s_axis_tdata[58:54];
      in_item.load_hour        <= s_axis_tdata[63:59];
      in_item.load_minute      <= s_axis_tdata[69:64];
    end
  end

  ccc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (core_en),
    .item   (in_item),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_en) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_result.elapsed, out_result.cal_minute,
                          out_result.cal_hour, out_result.cal_day, out_result.cal_month,
                          out_result.cal_year, out_result.tod_hours,
                          out_result.tod_minutes, out_result.tod_seconds};

endmodule

`default_nettype wire

>>> rtl/ccc_core.sv
// Time-of-day counter, Gregorian calendar registers and elapsed compare.
// Updates its state once per enabled request. Depends on ccc_pkg.
`default_nettype none

module ccc_core
  import ccc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire ccc_item_t   item,
  output ccc_result_t      result
);

  logic [SEC_W-1:0]   sec_count, sec_count_next;
  logic [MIN_W-1:0]   min_count, min_count_next;
  logic [HOUR_W-1:0]  hour_count, hour_count_next;
  logic [YEAR_W-1:0]  year_reg, year_reg_next;
  logic [MONTH_W-1:0] month_reg, month_reg_next;
  logic [DAY_W-1:0]   day_reg, day_reg_next;
  logic [HOUR_W-1:0]  cal_hour_reg, cal_hour_reg_next;
  logic [MIN_W-1:0]   cal_minute_reg, cal_minute_reg_next;
  logic               leap_year, leap_year_next;

  logic               sec_wrap, min_wrap, tick_req, advance_cal;
  logic [MIN_W:0]     cmin_inc;
  logic [HOUR_W:0]    chour_inc;
  logic [MONTH_W:0]   month_inc;
  logic               cmin_carry, chour_carry, day_carry, month_carry;
  logic [YEAR_W-1:0]  year_adv;
  logic [MONTH_W-1:0] month_adv;
  logic [DAY_W-1:0]   day_adv;
  logic [HOUR_W-1:0]  chour_adv;
  logic [MIN_W-1:0]   cmin_adv;
  logic [SOD_W-1:0]   cur_sod, prev_sod;
  logic [NEED_W-1:0]  need_sod;
  logic               elapsed;

  // Time of day wraps
  assign sec_wrap    = (sec_count == SEC_W'(59));
  assign min_wrap    = (min_count == MIN_W'(59));
  assign tick_req    = en && (item.command == CMD_TICK);
  assign advance_cal = tick_req && sec_wrap;

  // Calendar carry chain; each carry tested before truncation
  assign cmin_inc    = {1'b0, cal_minute_reg} + (MIN_W+1)'(1);
  assign chour_inc   = {1'b0, cal_hour_reg} + (HOUR_W+1)'(1);
  assign month_inc   = {1'b0, month_reg} + (MONTH_W+1)'(1);
  assign cmin_carry  = (cmin_inc >= (MIN_W+1)'(60));
  assign chour_carry = (chour_inc >= (HOUR_W+1)'(24));
  assign day_carry   = (day_reg >= month_len(month_reg, leap_year));
  assign month_carry = (month_inc >= (MONTH_W+1)'(13));

  always_comb begin
    cmin_adv  = cal_minute_reg;
    chour_adv = cal_hour_reg;
    day_adv   = day_reg;
    month_adv = month_reg;
    year_adv  = year_reg;
    if (!cmin_carry) begin
      cmin_adv = cmin_inc[MIN_W-1:0];
    end else begin
      cmin_adv = '0;
      if (!chour_carry) begin
        chour_adv = chour_inc[HOUR_W-1:0];
      end else begin
        chour_adv = '0;
        if (!day_carry) begin
          day_adv = day_reg + DAY_W'(1);
        end else begin
          day_adv = DAY_W'(1);
          if (!month_carry) begin
            month_adv = month_inc[MONTH_W-1:0];
          end else begin
            month_adv = MONTH_W'(1);
            year_adv  = year_reg + YEAR_W'(1);
          end
        end
      end
    end
  end

  // Elapsed compare on seconds of day, no midnight wrap
  assign cur_sod  = SOD_W'(hour_count) * SOD_W'(3600) + SOD_W'(min_count) * SOD_W'(60)
                  + SOD_W'(sec_count);
  assign prev_sod = SOD_W'(item.prev_hours) * SOD_W'(3600)
                  + SOD_W'(item.prev_minutes) * SOD_W'(60) + SOD_W'(item.prev_seconds);
  assign need_sod = NEED_W'(prev_sod) + NEED_W'(item.interval_seconds);

  // Next state and result
  always_comb begin
    sec_count_next      = sec_count;
    min_count_next      = min_count;
    hour_count_next     = hour_count;
    year_reg_next       = year_reg;
    month_reg_next      = month_reg;
    day_reg_next        = day_reg;
    cal_hour_reg_next   = cal_hour_reg;
    cal_minute_reg_next = cal_minute_reg;
    elapsed             = 1'b0;
    if (en) begin
      unique case (item.command)
        CMD_TICK: begin
          if (!sec_wrap) begin
            sec_count_next = sec_count + SEC_W'(1);
          end else begin
            sec_count_next = '0;
            if (!min_wrap) begin
              min_count_next = min_count + MIN_W'(1);
            end else begin
              min_count_next  = '0;
              hour_count_next = (hour_count == HOUR_W'(23)) ? '0
                                                            : hour_count + HOUR_W'(1);
            end
          end
          if (advance_cal) begin
            year_reg_next       = year_adv;
            month_reg_next      = month_adv;
            day_reg_next        = day_adv;
            cal_hour_reg_next   = chour_adv;
            cal_minute_reg_next = cmin_adv;
          end
        end
        CMD_QUERY: begin
          elapsed = ({1'b0, cur_sod} >= need_sod);
        end
        CMD_LOAD: begin
          if (item.load_year != '0)   year_reg_next       = item.load_year;
          if (item.load_month != '0)  month_reg_next      = item.load_month;
          if (item.load_day != '0)    day_reg_next        = item.load_day;
          if (item.load_hour != '0)   cal_hour_reg_next   = item.load_hour;
          if (item.load_minute != '0) cal_minute_reg_next = item.load_minute;
        end
        default: begin
        end
      endcase
    end
    leap_year_next = is_leap(year_reg_next);
  end

  assign result.tod_seconds = sec_count_next;
  assign result.tod_minutes = min_count_next;
  assign result.tod_hours   = hour_count_next;
  assign result.cal_year    = year_reg_next;
  assign result.cal_month   = month_reg_next;
  assign result.cal_day     = day_reg_next;
  assign result.cal_hour    = cal_hour_reg_next;
  assign result.cal_minute  = cal_minute_reg_next;
  assign result.elapsed     = elapsed;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_count      <= '0;
      min_count      <= '0;
      hour_count     <= '0;
      year_reg       <= RST_YEAR;
      month_reg      <= RST_MONTH;
      day_reg        <= RST_DAY;
      cal_hour_reg   <= RST_HOUR;
      cal_minute_reg <= RST_MINUTE;
      leap_year      <= 1'b0;
    end else begin
      sec_count      <= sec_count_next;
      min_count      <= min_count_next;
      hour_count     <= hour_count_next;
      year_reg       <= year_reg_next;
      month_reg      <= month_reg_next;
      day_reg        <= day_reg_next;
      cal_hour_reg   <= cal_hour_reg_next;
      cal_minute_reg <= cal_minute_reg_next;
      leap_year      <= leap_year_next;
    end
  end

  // Cached leap flag always tracks the stored year
  a_leap_tracks_year: assert property (@(posedge clk) disable iff (rst)
    leap_year == is_leap(year_reg))
    else $error("leap flag out of step with year");

  // Time of day stays in range
  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    (sec_count < SEC_W'(60)) && (min_count < MIN_W'(60)) && (hour_count < HOUR_W'(24)))
    else $error("time of day out of range");

  // A query leaves the state untouched; checked on the seconds count, year and calendar minute
  a_query_holds: assert property (@(posedge clk) disable iff (rst)
    en && (item.command == CMD_QUERY) |=>
      $stable(sec_count) && $stable(year_reg) && $stable(cal_minute_reg))
    else $error("query changed state");

  // Calendar minute moves only on a seconds rollover or a load
  a_cal_minute_cause: assert property (@(posedge clk) disable iff (rst)
    !(advance_cal || (en && (item.command == CMD_LOAD))) |=> $stable(cal_minute_reg))
    else $error("calendar minute changed without cause");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking bench for calendar_clock_counter: streams tick, query and load requests,
// predicts each result from its own copy of the clock and calendar, checks every field.
// Depends on ccc_pkg and the calendar_clock_counter RTL.
`timescale 1ns / 100ps

module testbench;
  import ccc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unused command code
  localparam int RANDOM_ITEMS = 440;
  localparam int IDLE_PCT     = 14;
  localparam int CALM_FIRST   = 250;              // no idling for these accepted requests
  localparam int CALM_LAST    = 350;
  localparam int HOLDOFF_AT   = 60;
  localparam int HOLDOFF_LEN  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 100000;

  typedef struct {
    logic [CMD_W-1:0]      command;
    logic [INTERVAL_W-1:0] interval;
    logic [HOUR_W-1:0]     ref_hours;
    logic [MIN_W-1:0]      ref_minutes;
    logic [SEC_W-1:0]      ref_seconds;
    logic [YEAR_W-1:0]     year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    logic [HOUR_W-1:0]     hour;
    logic [MIN_W-1:0]      minute;
  } clock_request_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata, low bit up: interval_seconds, prev_hours, prev_minutes, prev_seconds,
  // load_year, load_month, load_day, load_hour, load_minute, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // tuser: command
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata, low bit up: tod_seconds, tod_minutes, tod_hours, cal_year, cal_month,
  // cal_day, cal_hour, cal_minute, elapsed, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  clock_request_t pending_requests[$];
  ccc_result_t    expected_clock[$];
  clock_request_t drive_req;
  ccc_result_t    want;

  int  ticks_queued   = 0;
  int  request_total  = 0;
  int  accepted_count = 0;
  int  results_seen   = 0;
  int  fail_count     = 0;
  int  cycle_count    = 0;
  int  holdoff_left   = 0;
  bit  holdoff_done   = 1'b0;
  bit  req_taken      = 1'b0;

  // Predicted time of day and calendar
  int tod_sec, tod_min, tod_hour;
  int cal_yr, cal_mon, cal_dy, cal_hr, cal_mn;

  calendar_clock_counter dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gregorian month length; codes outside 1..12 have none
  function automatic int days_in_month(input int mon, input int yr);
    bit leap;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Apply one accepted request to the predicted state and return the result it gives
  function automatic ccc_result_t predict_clock(input logic [CMD_W-1:0] cmd,
                                                input logic [IN_TDATA_W-1:0] word);
    ccc_result_t res;
    int now_sod, need_sod;
    res.elapsed = 1'b0;
    if (cmd == CMD_TICK) begin
      tod_sec++;
      if (tod_sec == 60) begin
        tod_sec = 0;
        tod_min++;
        if (tod_min == 60) begin
          tod_min = 0;
          tod_hour = (tod_hour + 1) % 24;
        end
        // Carry tests look at the incremented value, so loaded out-of-range values carry
        cal_mn++;
        if (cal_mn >= 60) begin
          cal_mn = 0;
          cal_hr++;
          if (cal_hr >= 24) begin
            cal_hr = 0;
            cal_dy++;
            if (cal_dy > days_in_month(cal_mon, cal_yr)) begin
              cal_dy = 1;
              cal_mon++;
              if (cal_mon >= 13) begin
                cal_mon = 1;
                cal_yr = (cal_yr + 1) % 65536;
              end
            end
          end
        end
      end
    end else if (cmd == CMD_QUERY) begin
      // No wrap across midnight; reference fields are used as given
      now_sod  = tod_hour * 3600 + tod_min * 60 + tod_sec;
      need_sod = int'(word[21:17]) * 3600 + int'(word[27:22]) * 60 + int'(word[33:28])
               + int'(word[16:0]);
      res.elapsed = (now_sod >= need_sod);
    end else if (cmd == CMD_LOAD) begin
      // Zero keeps the field
      if (word[49:34] != 0) cal_yr  = int'(word[49:34]);
      if (word[53:50] != 0) cal_mon = int'(word[53:50]);
      if (word[58:54] != 0) cal_dy  = int'(word[58:54]);
      if (word[63:59] != 0) cal_hr  = int'(word[63:59]);
      if (word[69:64] != 0) cal_mn  = int'(word[69:64]);
    end
    res.tod_seconds = SEC_W'(tod_sec);
    res.tod_minutes = MIN_W'(tod_min);
    res.tod_hours   = HOUR_W'(tod_hour);
    res.cal_year    = YEAR_W'(cal_yr);
    res.cal_month   = MONTH_W'(cal_mon);
    res.cal_day     = DAY_W'(cal_dy);
    res.cal_hour    = HOUR_W'(cal_hr);
    res.cal_minute  = MIN_W'(cal_mn);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("ERROR t=%0t result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
  endtask

  // Queue one request; keep a running tick count for near-boundary queries
  task automatic add_request(input logic [CMD_W-1:0] cmd, input int interval,
                             input int rh, input int rm, input int rs, input int yr,
                             input int mo, input int dy, input int hr, input int mn);
    clock_request_t r;
    r.command     = cmd;
    r.interval    = INTERVAL_W'(interval);
    r.ref_hours   = HOUR_W'(rh);
    r.ref_minutes = MIN_W'(rm);
    r.ref_seconds = SEC_W'(rs);
    r.year        = YEAR_W'(yr);
    r.month       = MONTH_W'(mo);
    r.day         = DAY_W'(dy);
    r.hour        = HOUR_W'(hr);
    r.minute      = MIN_W'(mn);
    pending_requests.push_back(r);
    if (cmd == CMD_TICK) ticks_queued++;
  endtask

  // Full-range random payload, whatever the command ignores
  task automatic add_noise(input logic [CMD_W-1:0] cmd);
    add_request(cmd, $urandom_range(131071), $urandom_range(31), $urandom_range(63),
                $urandom_range(63), $urandom_range(65535), $urandom_range(15),
                $urandom_range(31), $urandom_range(31), $urandom_range(63));
  endtask

  // Query whose reference plus interval lands within a second of the current time
  task automatic add_near_query();
    int now_sod, span, ref_sod;
    now_sod = ticks_queued % 86400;
    span    = $urandom_range(now_sod);
    ref_sod = now_sod - span + $urandom_range(2) - 1;
    if (ref_sod < 0) ref_sod = 0;
    add_request(CMD_QUERY, span, ref_sod / 3600, (ref_sod / 60) % 60, ref_sod % 60,
                0, 0, 0, 0, 0);
  endtask

  // Load a calendar sitting on a carry boundary, sometimes with kept or odd fields
  task automatic add_edge_load();
    int yr, mo, dy, hr, mn, len;
    case ($urandom_range(7))
      0:       yr = 65535;
      1:       yr = 2000;
      2:       yr = 1900;
      3:       yr = 2100;
      4:       yr = 2400;
      5:       yr = 2024;
      6:       yr = 2023;
      default: yr = $urandom_range(65535, 1);
    endcase
    if ($urandom_range(9) == 0) mo = $urandom_range(15, 13);
    else if ($urandom_range(2) == 0) mo = 2;
    else mo = $urandom_range(12, 1);
    len = days_in_month(mo, yr);
    case ($urandom_range(3))
      0, 1:    dy = (len == 0) ? 31 : len;
      2:       dy = (len > 1) ? len - 1 : 1;
      default: dy = $urandom_range(31, 1);
    endcase
    hr = ($urandom_range(4) == 0) ? $urandom_range(31, 1) : 23;
    case ($urandom_range(5))
      4:       mn = $urandom_range(63, 60);
      5:       mn = $urandom_range(58, 1);
      default: mn = 59;
    endcase
    if ($urandom_range(11) == 0) yr = 0;
    if ($urandom_range(11) == 0) mo = 0;
    if ($urandom_range(11) == 0) dy = 0;
    if ($urandom_range(11) == 0) hr = 0;
    if ($urandom_range(11) == 0) mn = 0;
    add_request(CMD_LOAD, 0, 0, 0, 0, yr, mo, dy, hr, mn);
  endtask

  // Drive requests at the falling edge; hold a request until it is taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (pending_requests.size() != 0 &&
          ((accepted_count >= CALM_FIRST && accepted_count < CALM_LAST) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        drive_req = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drive_req.command;
        s_axis_tdata  <= {2'b00, drive_req.minute, drive_req.hour, drive_req.day,
                          drive_req.month, drive_req.year, drive_req.ref_seconds,
                          drive_req.ref_minutes, drive_req.ref_hours, drive_req.interval};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Count out one long receiver hold-off so the block backs up into its input
  always @(negedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && accepted_count >= HOLDOFF_AT) begin
      holdoff_left <= HOLDOFF_LEN;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Stall the result side at random outside the calm stretch, and throughout the hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (holdoff_left == 0) &&
                       ((accepted_count >= CALM_FIRST && accepted_count < CALM_LAST) ||
                        $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check results against the oldest prediction, then predict for a taken request
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      tod_sec  = 0;
      tod_min  = 0;
      tod_hour = 0;
      cal_yr   = int'(RST_YEAR);
      cal_mon  = int'(RST_MONTH);
      cal_dy   = int'(RST_DAY);
      cal_hr   = int'(RST_HOUR);
      cal_mn   = int'(RST_MINUTE);
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_clock.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_clock.pop_front();
          check_field("tod_seconds", 16'(m_axis_tdata[5:0]),   16'(want.tod_seconds));
          check_field("tod_minutes", 16'(m_axis_tdata[11:6]),  16'(want.tod_minutes));
          check_field("tod_hours",   16'(m_axis_tdata[16:12]), 16'(want.tod_hours));
          check_field("cal_year",    m_axis_tdata[32:17],      want.cal_year);
          check_field("cal_month",   16'(m_axis_tdata[36:33]), 16'(want.cal_month));
          check_field("cal_day",     16'(m_axis_tdata[41:37]), 16'(want.cal_day));
          check_field("cal_hour",    16'(m_axis_tdata[46:42]), 16'(want.cal_hour));
          check_field("cal_minute",  16'(m_axis_tdata[52:47]), 16'(want.cal_minute));
          check_field("elapsed",     16'(m_axis_tdata[53]),    16'(want.elapsed));
        end
        results_seen++;
      end
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_clock.push_back(predict_clock(s_axis_tuser, s_axis_tdata));
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Directed: query extremes, unused command, load extremes and kept fields
    add_request(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_QUERY, 131071, 31, 63, 63, 0, 0, 0, 0, 0);
    add_request(CMD_SPARE, 131071, 31, 63, 63, 65535, 15, 31, 31, 63);
    add_request(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_LOAD, 131071, 31, 63, 63, 65535, 15, 31, 31, 63);
    add_request(CMD_TICK, 131071, 31, 63, 63, 65535, 15, 31, 31, 63);
    add_request(CMD_QUERY, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_request(CMD_QUERY, 0, 0, 0, 2, 0, 0, 0, 0, 0);
    add_request(CMD_LOAD, 0, 0, 0, 0, 2000, 2, 29, 23, 59);
    add_request(CMD_LOAD, 0, 0, 0, 0, 1, 1, 1, 1, 1);
    add_request(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_LOAD, 0, 0, 0, 0, 2024, 12, 31, 23, 59);
    add_request(CMD_QUERY, 2, 0, 0, 0, 0, 0, 0, 0, 0);
    add_request(CMD_QUERY, 0, 0, 0, 3, 0, 0, 0, 0, 0);
    add_request(CMD_SPARE, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // Random: mostly boundary loads followed by ticks up to a rollover, some noise
    request_total = pending_requests.size() + RANDOM_ITEMS;
    while (pending_requests.size() < request_total) begin
      if ($urandom_range(9) < 7) begin
        int ticks_left;
        add_edge_load();
        ticks_left = 60 - ticks_queued % 60 + (($urandom_range(3) == 0) ? 60 : 0);
        while (ticks_left > 0) begin
          int pick;
          pick = $urandom_range(99);
          if (pick < 12) begin
            add_near_query();
          end else if (pick < 14) begin
            add_noise(CMD_SPARE);
          end else begin
            if ($urandom_range(3) == 0) add_noise(CMD_TICK);
            else add_request(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            ticks_left--;
          end
        end
      end else begin
        repeat ($urandom_range(12, 4)) add_noise(CMD_W'($urandom_range(3)));
      end
    end
    request_total = pending_requests.size();

    // Release reset, then wait for every request to be answered
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    while (accepted_count != request_total || expected_clock.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> calendar_clock_counter.f
rtl/ccc_pkg.sv
rtl/ccc_core.sv
rtl/calendar_clock_counter.sv
verif/testbench.sv
